// File: rtl/qosa_pkg.sv
`default_nettype none
package qosa_pkg;

	localparam int NUM_DIRS      = 2;
	localparam int NUM_EDGES     = 4;
	localparam int NUM_VERTS     = 4;
	localparam int PTS_PER_EDGE  = 6;

	typedef enum logic [1:0] {
		SIGN_ZERO = 2'b00,
		SIGN_POS  = 2'b01,
		SIGN_NEG  = 2'b10
	} sign_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage
`default_nettype wire

// File: rtl/quad_overlap_separating_axis.sv
`default_nettype none
// Separating-axis overlap test for two convex quadrilaterals, one pair per beat.
// A new pair is taken every cycle unless a full pipeline is held by the result
// side; the collide flag for a pair is registered in the last of the stages below.
// The four stages are: edge and offset differences, 96 parallel COORD_BITS+1
// wide multiplies, dot sums with sign, and the per-edge decision. Each vertex
// packs x above y, both signed COORD_BITS wide; the fraction width does not
// affect the answer.
module quad_overlap_separating_axis #(
	parameter int COORD_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         pair_valid,
	output logic        pair_ready,
	input  wire  [31:0] rect_a_v0,
	input  wire  [31:0] rect_a_v1,
	input  wire  [31:0] rect_a_v2,
	input  wire  [31:0] rect_a_v3,
	input  wire  [31:0] rect_b_v0,
	input  wire  [31:0] rect_b_v1,
	input  wire  [31:0] rect_b_v2,
	input  wire  [31:0] rect_b_v3,
	output logic        result_valid,
	input  wire         result_ready,
	output logic        collide
);
	import qosa_pkg::*;

	localparam int W = COORD_BITS + 1;

	logic [31:0]                 word [NUM_DIRS][NUM_VERTS];
	logic signed [COORD_BITS-1:0] vx  [NUM_DIRS][NUM_VERTS];
	logic signed [COORD_BITS-1:0] vy  [NUM_DIRS][NUM_VERTS];

	logic signed [W-1:0] rot_x_s1 [NUM_DIRS][NUM_EDGES];
	logic signed [W-1:0] rot_y_s1 [NUM_DIRS][NUM_EDGES];
	logic signed [W-1:0] dif_x_s1 [NUM_DIRS][NUM_EDGES][PTS_PER_EDGE];
	logic signed [W-1:0] dif_y_s1 [NUM_DIRS][NUM_EDGES][PTS_PER_EDGE];
	sign_t               side     [NUM_DIRS][NUM_EDGES][PTS_PER_EDGE];

	logic      valid_s1, valid_s2, valid_s3, valid_s4;
	stage_en_t en;

	assign word[0][0] = rect_a_v0;
	assign word[0][1] = rect_a_v1;
	assign word[0][2] = rect_a_v2;
	assign word[0][3] = rect_a_v3;
	assign word[1][0] = rect_b_v0;
	assign word[1][1] = rect_b_v1;
	assign word[1][2] = rect_b_v2;
	assign word[1][3] = rect_b_v3;

	for (genvar q = 0; q < NUM_DIRS; q++) begin : g_unpack_q
		for (genvar i = 0; i < NUM_VERTS; i++) begin : g_unpack_i
			logic [63:0] wide;
			assign wide     = {32'd0, word[q][i]};
			assign vx[q][i] = wide[COORD_BITS +: COORD_BITS];
			assign vy[q][i] = wide[0 +: COORD_BITS];
		end
	end

	// advance a stage when it is empty or its occupant moves on
	assign en.s4      = ~valid_s4 | result_ready;
	assign en.s3      = ~valid_s3 | en.s4;
	assign en.s2      = ~valid_s2 | en.s3;
	assign en.s1      = ~valid_s1 | en.s2;
	assign pair_ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= pair_valid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
		end
	end

	for (genvar d = 0; d < NUM_DIRS; d++) begin : g_dir
		for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
			localparam int BI = (e + 3) % NUM_VERTS;

			always_ff @(posedge clk) begin
				if (en.s1) begin
					rot_x_s1[d][e] <= W'(vy[d][e]) - W'(vy[d][BI]);
					rot_y_s1[d][e] <= W'(vx[d][BI]) - W'(vx[d][e]);
				end
			end

			for (genvar j = 0; j < PTS_PER_EDGE; j++) begin : g_pt
				localparam int PD = (j < NUM_VERTS) ? (1 - d) : d;
				localparam int PI = (j < NUM_VERTS) ? j : ((e + j - 3) % NUM_VERTS);

				always_ff @(posedge clk) begin
					if (en.s1) begin
						dif_x_s1[d][e][j] <= W'(vx[PD][PI]) - W'(vx[d][BI]);
						dif_y_s1[d][e][j] <= W'(vy[PD][PI]) - W'(vy[d][BI]);
					end
				end

				qosa_dot #(
					.W(W)
				) u_dot (
					.clk   (clk),
					.en    (en),
					.rot_x (rot_x_s1[d][e]),
					.rot_y (rot_y_s1[d][e]),
					.dif_x (dif_x_s1[d][e][j]),
					.dif_y (dif_y_s1[d][e][j]),
					.side  (side[d][e][j])
				);
			end
		end
	end

	qosa_decide u_decide (
		.clk     (clk),
		.en      (en),
		.side    (side),
		.collide (collide)
	);

	assign result_valid = valid_s4;

`ifndef ASSERT_OFF
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> pair_ready)
		else $error("input held off while result side is ready");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair_ready |-> (valid_s1 && valid_s2 && valid_s3 && result_valid && !result_ready))
		else $error("input held off with a free stage");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && pair_ready) ##1 result_ready ##1 result_ready ##1 result_ready
		|=> result_valid)
		else $error("accepted beat did not reach the output in four cycles");

	a_result_from_s3: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s3))
		else $error("result appeared without an item in the sign stage");
`endif

endmodule
`default_nettype wire

// File: rtl/qosa_dot.sv
`default_nettype none
module qosa_dot #(
	parameter int W = 17
) (
	input  wire                  clk,
	input  qosa_pkg::stage_en_t  en,
	input  wire  signed [W-1:0]  rot_x,
	input  wire  signed [W-1:0]  rot_y,
	input  wire  signed [W-1:0]  dif_x,
	input  wire  signed [W-1:0]  dif_y,
	output qosa_pkg::sign_t      side
);
	import qosa_pkg::*;

	logic signed [2*W-1:0] prod_x_s2;
	logic signed [2*W-1:0] prod_y_s2;
	logic signed [2*W:0]   sum;
	sign_t                 side_s3;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_x_s2 <= rot_x * dif_x;
			prod_y_s2 <= rot_y * dif_y;
		end
	end

	assign sum = {prod_x_s2[2*W-1], prod_x_s2} + {prod_y_s2[2*W-1], prod_y_s2};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			if (sum[2*W]) begin
				side_s3 <= SIGN_NEG;
			end else if (sum == '0) begin
				side_s3 <= SIGN_ZERO;
			end else begin
				side_s3 <= SIGN_POS;
			end
		end
	end

	assign side = side_s3;

endmodule
`default_nettype wire

// File: rtl/qosa_decide.sv
`default_nettype none
module qosa_decide (
	input  wire                  clk,
	input  qosa_pkg::stage_en_t  en,
	input  qosa_pkg::sign_t      side [qosa_pkg::NUM_DIRS][qosa_pkg::NUM_EDGES]
	                                  [qosa_pkg::PTS_PER_EDGE],
	output logic                 collide
);
	import qosa_pkg::*;

	logic collide_s4;
	logic sep;

	always_comb begin
		sign_t merged;
		logic  cand;
		sep    = 1'b0;
		merged = SIGN_ZERO;
		cand   = 1'b1;
		for (int d = 0; d < NUM_DIRS; d++) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				merged = side[d][e][0];
				cand   = 1'b1;
				for (int k = 1; k < NUM_VERTS; k++) begin
					if (cand) begin
						if (merged == SIGN_ZERO) begin
							merged = side[d][e][k];
						end else if (side[d][e][k] != SIGN_ZERO && side[d][e][k] != merged) begin
							cand = 1'b0;
						end
					end
				end
				if (cand && (side[d][e][4] != merged || side[d][e][5] != merged)) begin
					sep = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			collide_s4 <= ~sep;
		end
	end

	assign collide = collide_s4;

endmodule
`default_nettype wire
